// ===== src/dbe_pkg.sv =====
package dbe_pkg;

	// Widest parity field and the byte cells that hold it
	localparam int PB_BITS  = 192;
	localparam int PB_CELLS = PB_BITS / 8;
	localparam int CNT_W    = $clog2(PB_CELLS + 1);
	localparam int TAP_W    = 15;
	localparam int POS_W    = 13;

	// Register indexes (paddr bit 2)
	localparam logic REG_CODE_MODE  = 1'b0;
	localparam logic REG_BYTE_COUNT = 1'b1;

	localparam logic [POS_W-1:0] BYTE_COUNT_RST = 13'd2001;

	typedef enum logic [1:0] {
		MODE_NORMAL_T12,
		MODE_NORMAL_T10,
		MODE_NORMAL_T8,
		MODE_SHORT_T12
	} code_mode_t;

	// Per-cell control: shift/divide enable, inside the active width, feedback byte
	typedef struct packed {
		logic       en;
		logic       active;
		logic [7:0] fb;
	} cell_ctl_t;

	localparam logic [16:0] NORMAL_MINPOLY [12] = '{
		17'h1002D, 17'h10173, 17'h10FBD, 17'h15A55, 17'h11F2F, 17'h1F7B5,
		17'h1AF65, 17'h17367, 17'h10EA1, 17'h175A7, 17'h13A2D, 17'h11AE3
	};
	localparam logic [16:0] SHORT_MINPOLY [12] = '{
		17'h0402B, 17'h04941, 17'h04647, 17'h05591, 17'h06B55, 17'h06389,
		17'h06CE5, 17'h04F21, 17'h0460F, 17'h05A49, 17'h05811, 17'h065EF
	};

	// Parity bytes of a codeword for each mode
	function automatic logic [CNT_W-1:0] parity_bytes(input code_mode_t mode);
		logic [CNT_W-1:0] n;
		case (mode)
			MODE_NORMAL_T12: n = CNT_W'(24);
			MODE_NORMAL_T10: n = CNT_W'(20);
			MODE_NORMAL_T8:  n = CNT_W'(16);
			MODE_SHORT_T12:  n = CNT_W'(21);
			default:         n = CNT_W'(24);
		endcase
		return n;
	endfunction

	// Generator taps: product of the minimal polynomials, top term dropped
	function automatic logic [PB_BITS-1:0] bch_gen(input code_mode_t mode);
		logic [PB_BITS+15:0] p;
		logic [PB_BITS+15:0] r;
		logic [16:0]         m;
		int                  nf;
		int                  nb;
		nf = (mode == MODE_NORMAL_T10) ? 10 : ((mode == MODE_NORMAL_T8) ? 8 : 12);
		nb = 8 * int'(parity_bytes(mode));
		p = '0;
		p[0] = 1'b1;
		for (int i = 0; i < 12; i++) begin
			if (i < nf) begin
				m = (mode == MODE_SHORT_T12) ? SHORT_MINPOLY[i] : NORMAL_MINPOLY[i];
				r = '0;
				for (int k = 0; k < 17; k++) begin
					if (m[k])
						r = r ^ (p << k);
				end
				p = r;
			end
		end
		for (int b = 0; b < PB_BITS + 16; b++) begin
			if (b >= nb)
				p[b] = 1'b0;
		end
		return p[PB_BITS-1:0];
	endfunction

	localparam logic [PB_BITS-1:0] GEN_N12 = bch_gen(MODE_NORMAL_T12);
	localparam logic [PB_BITS-1:0] GEN_N10 = bch_gen(MODE_NORMAL_T10);
	localparam logic [PB_BITS-1:0] GEN_N8  = bch_gen(MODE_NORMAL_T8);
	localparam logic [PB_BITS-1:0] GEN_S12 = bch_gen(MODE_SHORT_T12);

endpackage

// ===== src/dvbs2_bch_encoder.sv =====
// DVB-S2 outer BCH encoder, systematic, byte wide. Message bytes enter on
// s_tdata MSB first, one per cycle unless stalled, and come out unchanged
// on m_tdata with m_tuser low. After data_byte_count bytes the remainder
// follows as 24, 20, 16 or 21 parity bytes (normal t=12, t=10, t=8, short
// t=12) with m_tuser high and m_tlast on the final one; s_tready stays low
// for those cycles, since the output port carries one byte per cycle. The
// remainder lives in a chain of 24 byte cells that divide a byte per cycle
// and shift the parity out. Write code_mode (0x0) and data_byte_count
// (0x4) only between transactions; a count of 0 means 8192 bytes.
module dvbs2_bch_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// message in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	// codeword out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tuser,   // [0] is_parity
	output logic        m_tlast,   // frame_last
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dbe_pkg::*;

	code_mode_t         mode_q;
	logic [POS_W-1:0]   count_q;
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   emit_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_par_q;
	logic               out_last_q;

	logic [PB_BITS-1:0] gen;
	logic [PB_BITS+6:0] gen_x;
	logic [7:0]         top_byte;
	logic [7:1]         g_top;
	logic [CNT_W-1:0]   nbytes;
	logic [7:0]         fb;
	logic [7:0]         cell_q [PB_CELLS];
	cell_ctl_t          ctl [PB_CELLS];

	logic               slot_free;
	logic               emitting;
	logic               accept_in;
	logic               emit_step;
	logic [POS_W-1:0]   pos_next;
	logic               frame_end;
	logic               cfg_wr;

	assign slot_free = !out_valid_q || m_tready;
	assign emitting  = (emit_q != '0);
	assign s_tready  = !emitting && slot_free;
	assign accept_in = s_tvalid && s_tready;
	assign emit_step = emitting && slot_free;
	assign pos_next  = pos_q + POS_W'(1);
	assign frame_end = (pos_next == count_q);

	// Select generator, top cell and the generator's top bits for the mode
	always_comb begin
		case (mode_q)
			MODE_NORMAL_T12: begin
				gen      = GEN_N12;
				top_byte = cell_q[23];
				g_top    = GEN_N12[191:185];
			end
			MODE_NORMAL_T10: begin
				gen      = GEN_N10;
				top_byte = cell_q[19];
				g_top    = GEN_N10[159:153];
			end
			MODE_NORMAL_T8: begin
				gen      = GEN_N8;
				top_byte = cell_q[15];
				g_top    = GEN_N8[127:121];
			end
			MODE_SHORT_T12: begin
				gen      = GEN_S12;
				top_byte = cell_q[20];
				g_top    = GEN_S12[167:161];
			end
			default: begin
				gen      = GEN_N12;
				top_byte = cell_q[23];
				g_top    = GEN_N12[191:185];
			end
		endcase
	end

	assign nbytes = parity_bytes(mode_q);
	assign gen_x  = {gen, 7'b0};

	dbe_fb u_fb (
		.top_byte  (top_byte),
		.data_byte (s_tdata),
		.g_top     (g_top),
		.fb        (fb)
	);

	// Cell chain: divide on a message byte, plain shift while emitting parity
	for (genvar k = 0; k < PB_CELLS; k++) begin : g_cell
		logic [7:0] prev;

		assign ctl[k].en     = accept_in || emit_step;
		assign ctl[k].active = (CNT_W'(k) < nbytes);
		assign ctl[k].fb     = accept_in ? fb : 8'h00;

		if (k == 0) begin : g_first
			assign prev = 8'h00;
		end else begin : g_rest
			assign prev = cell_q[k-1];
		end

		dbe_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[k]),
			.prev_byte (prev),
			.taps      (gen_x[8*k+14 -: TAP_W]),
			.q         (cell_q[k])
		);
	end

	// Count message bytes and parity bytes still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			emit_q <= '0;
		end else begin
			if (accept_in)
				pos_q <= frame_end ? '0 : pos_next;
			if (accept_in && frame_end)
				emit_q <= nbytes;
			else if (emit_step)
				emit_q <= emit_q - CNT_W'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept_in || emit_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept_in) begin
			out_byte_q <= s_tdata;
			out_par_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else if (emit_step) begin
			out_byte_q <= top_byte;
			out_par_q  <= 1'b1;
			out_last_q <= (emit_q == CNT_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_par_q;
	assign m_tlast  = out_last_q;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL_T12;
			count_q <= BYTE_COUNT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CODE_MODE:  mode_q  <= code_mode_t'(pwdata[1:0]);
				REG_BYTE_COUNT: count_q <= pwdata[POS_W-1:0];
				default:        mode_q  <= mode_q;
			endcase
		end
	end

	// Read back; unaligned addresses read zero
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[2])
				REG_CODE_MODE:  prdata = {30'b0, mode_q};
				REG_BYTE_COUNT: prdata = {{(32-POS_W){1'b0}}, count_q};
				default:        prdata = '0;
			endcase
		end
	end

endmodule

// ===== src/dbe_fb.sv =====
module dbe_fb (
	input  logic [7:0] top_byte,
	input  logic [7:0] data_byte,
	input  logic [7:1] g_top,
	output logic [7:0] fb
);
	import dbe_pkg::*;

	logic [7:0] fbv;
	logic       acc;

	// Feedback of eight serial division steps, bit 7 of the data first;
	// fbv[j] multiplies the generator shifted up by j
	always_comb begin
		fbv = '0;
		acc = 1'b0;
		for (int b = 0; b < 8; b++) begin
			acc = top_byte[7-b] ^ data_byte[7-b];
			for (int c = 0; c < 8; c++) begin
				if (c < b)
					acc = acc ^ (fbv[7-c] & g_top[8-b+c]);
			end
			fbv[7-b] = acc;
		end
	end

	assign fb = fbv;

endmodule

// ===== src/dbe_cell.sv =====
module dbe_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dbe_pkg::cell_ctl_t ctl,
	input  logic [7:0]        prev_byte,
	input  logic [14:0]       taps,
	output logic [7:0]        q
);
	import dbe_pkg::*;

	logic [7:0]       contrib;
	logic [TAP_W-1:0] taps_w;
	logic [7:0]       q_q;

	assign taps_w = taps;

	// XOR in the generator window for each feedback bit
	always_comb begin
		contrib = '0;
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++) begin
				contrib[i] = contrib[i] ^ (ctl.fb[j] & taps_w[i-j+7]);
			end
		end
	end

	// Take the neighbor's byte XOR the generator terms; cells above the code width read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
		end else if (ctl.en) begin
			q_q <= ctl.active ? (prev_byte ^ contrib) : 8'h00;
		end
	end

	assign q = q_q;

endmodule

// ===== src/dbe_checker.sv =====
module dbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// Frame end is only ever flagged on a parity byte
	a_last_is_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("tlast on a message byte");

	// Parity bytes run back to back until the last one
	a_parity_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && m_tuser)
		else $error("gap or message byte inside parity run");

	// No message byte is taken while parity is still owed
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && !m_tlast |-> !s_tready)
		else $error("input accepted during parity output");

	// Each accepted message byte shows up next cycle as a message byte
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid && !m_tuser)
		else $error("message byte not forwarded");

	// Stalled output holds its byte
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed under stall");

endmodule

bind dvbs2_bch_encoder dbe_checker u_dbe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== test/dvbs2_bch_encoder_test.sv =====
module dvbs2_bch_encoder_test;

	import dbe_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_ITEMS   = 60;
	localparam int SETTLE       = 8;
	localparam int STALL_LIMIT  = 1000;

	// One codeword byte as it leaves the encoder
	typedef struct packed {
		logic [7:0] data;
		logic       parity;
		logic       last;
	} cw_byte_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Encoder state mirrored on the test side
	logic [191:0] gen_taps [4];
	logic [191:0] remainder = '0;
	logic [12:0]  msg_pos   = '0;
	code_mode_t   cfg_mode  = MODE_NORMAL_T12;
	logic [12:0]  cfg_count = BYTE_COUNT_RST;

	logic [7:0] msg_q [$];
	cw_byte_t   codeword_q [$];
	cw_byte_t   head;

	bit jitter_on = 1'b0;
	int src_gap;
	int sink_gap;
	int bytes_taken;
	int pushed_total;
	int error_count;
	int stall_cycles;

	dvbs2_bch_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int parity_width(input code_mode_t m);
		case (m)
			MODE_NORMAL_T10: return 160;
			MODE_NORMAL_T8:  return 128;
			MODE_SHORT_T12:  return 168;
			default:         return 192;
		endcase
	endfunction

	// Minimal polynomials of the normal (degree 16) and short (degree 14) codes
	function automatic logic [16:0] min_poly(input bit short_frame, input int i);
		logic [16:0] p;
		if (short_frame) begin
			case (i)
				0: p = 17'h0402B;  1: p = 17'h04941;  2: p = 17'h04647;  3: p = 17'h05591;
				4: p = 17'h06B55;  5: p = 17'h06389;  6: p = 17'h06CE5;  7: p = 17'h04F21;
				8: p = 17'h0460F;  9: p = 17'h05A49; 10: p = 17'h05811; default: p = 17'h065EF;
			endcase
		end else begin
			case (i)
				0: p = 17'h1002D;  1: p = 17'h10173;  2: p = 17'h10FBD;  3: p = 17'h15A55;
				4: p = 17'h11F2F;  5: p = 17'h1F7B5;  6: p = 17'h1AF65;  7: p = 17'h17367;
				8: p = 17'h10EA1;  9: p = 17'h175A7; 10: p = 17'h13A2D; default: p = 17'h11AE3;
			endcase
		end
		return p;
	endfunction

	// Multiply out the generator and keep the taps below its leading term
	function automatic logic [191:0] taps_for_mode(input code_mode_t m);
		logic [207:0] acc;
		logic [207:0] nxt;
		logic [16:0]  mp;
		int           factors;
		factors = (m == MODE_NORMAL_T10) ? 10 : ((m == MODE_NORMAL_T8) ? 8 : 12);
		acc = 208'd1;
		for (int i = 0; i < factors; i++) begin
			mp = min_poly(m == MODE_SHORT_T12, i);
			nxt = '0;
			for (int j = 0; j < 17; j++) begin
				if (mp[j])
					nxt = nxt ^ (acc << j);
			end
			acc = nxt;
		end
		return acc[191:0] & ({192{1'b1}} >> (192 - parity_width(m)));
	endfunction

	// Divide one message byte into the remainder and queue the codeword bytes it yields
	function automatic void encode_byte(input logic [7:0] d);
		int           nb;
		logic         fb;
		logic [191:0] mask;
		nb = parity_width(cfg_mode);
		mask = {192{1'b1}} >> (192 - nb);
		remainder = remainder & mask;
		for (int b = 7; b >= 0; b--) begin
			fb = remainder[nb-1] ^ d[b];
			remainder = (remainder << 1) & mask;
			if (fb)
				remainder = remainder ^ gen_taps[cfg_mode];
		end
		codeword_q.push_back('{data: d, parity: 1'b0, last: 1'b0});
		msg_pos = msg_pos + 13'd1;
		if (msg_pos == cfg_count) begin
			for (int k = 0; k < nb / 8; k++)
				codeword_q.push_back('{data: remainder[nb-1-8*k -: 8], parity: 1'b1,
					last: (k == nb / 8 - 1)});
			remainder = '0;
			msg_pos = '0;
		end
	endfunction

	function automatic void log_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Source: feed message bytes, with random gaps while jitter is on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			src_gap <= 0;
			bytes_taken <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_byte(s_tdata);
				bytes_taken <= bytes_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (jitter_on && $urandom_range(0, 7) == 0) begin
					src_gap <= $urandom_range(0, 17);
					s_tvalid <= 1'b0;
				end else if (msg_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= msg_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink: check each codeword transaction, stall in random bursts while jitter is on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (codeword_q.size() == 0) begin
					log_error($sformatf("unexpected byte %02h user %b last %b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					head = codeword_q.pop_front();
					if (m_tdata !== head.data || m_tuser !== head.parity || m_tlast !== head.last)
						log_error($sformatf("expected %02h user %b last %b, got %02h user %b last %b",
							head.data, head.parity, head.last, m_tdata, m_tuser, m_tlast));
				end
			end
			if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (jitter_on && $urandom_range(0, 7) == 0) begin
				sink_gap <= $urandom_range(0, 17);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("dvbs2_bch_encoder test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == REG_CODE_MODE)
			cfg_mode = code_mode_t'(val[1:0]);
		else
			cfg_count = val[12:0];
	endtask

	task automatic push_byte(input logic [7:0] b);
		msg_q.push_back(b);
		pushed_total++;
	endtask

	task automatic send_random(input int n);
		repeat (n) push_byte(8'($urandom));
	endtask

	// Wait until every queued byte is taken and every codeword byte has come out
	task automatic drain();
		while (bytes_taken != pushed_total || codeword_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_cfg(input code_mode_t m, input int cnt);
		drain();
		apb_write({REG_CODE_MODE, 2'b00}, 32'(m));
		apb_write({REG_BYTE_COUNT, 2'b00}, 32'(cnt));
	endtask

	// Send the bytes that close the current frame
	task automatic finish_frame();
		logic [12:0] left;
		left = cfg_count - msg_pos;
		send_random((left == 13'd0) ? 8192 : int'(left));
	endtask

	initial begin
		int         start;
		int         k;
		int         cnt;
		code_mode_t m;
		for (int i = 0; i < 4; i++)
			gen_taps[i] = taps_for_mode(code_mode_t'(i));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		jitter_on = 1'b1;

		// Reset settings: a few bytes in normal t=12, then close the frame early
		send_random(5);
		drain();
		apb_write({REG_BYTE_COUNT, 2'b00}, 32'd6);
		finish_frame();

		// One-byte frames in every mode and a two-byte short t=12 frame, at the data extremes
		set_cfg(MODE_NORMAL_T12, 1);
		push_byte(8'hFF);
		set_cfg(MODE_NORMAL_T10, 1);
		push_byte(8'h00);
		set_cfg(MODE_NORMAL_T8, 1);
		push_byte(8'h80);
		set_cfg(MODE_SHORT_T12, 1);
		push_byte(8'h01);
		set_cfg(MODE_SHORT_T12, 2);
		push_byte(8'hFF);
		push_byte(8'hFF);

		// Narrow the mode mid-frame
		set_cfg(MODE_NORMAL_T12, 4);
		push_byte(8'hC3);
		push_byte(8'h5A);
		drain();
		apb_write({REG_CODE_MODE, 2'b00}, 32'(MODE_SHORT_T12));
		push_byte(8'hFF);
		push_byte(8'h00);

		// Widen the mode mid-frame
		set_cfg(MODE_NORMAL_T8, 3);
		push_byte(8'h7E);
		drain();
		apb_write({REG_CODE_MODE, 2'b00}, 32'(MODE_NORMAL_T12));
		push_byte(8'h81);
		push_byte(8'h18);

		// Raise the count mid-frame
		set_cfg(MODE_NORMAL_T10, 2);
		push_byte(8'h01);
		drain();
		apb_write({REG_BYTE_COUNT, 2'b00}, 32'd5);
		push_byte(8'h02);
		push_byte(8'h04);
		push_byte(8'h08);
		push_byte(8'h10);

		// Random frames, mostly short, some broken by a setting change mid-frame
		start = pushed_total;
		while (pushed_total - start < RANDOM_ITEMS) begin
			if (pushed_total - start >= RANDOM_ITEMS - CALM_ITEMS)
				jitter_on = 1'b0;
			m = code_mode_t'($urandom_range(0, 3));
			cnt = ($urandom_range(0, 11) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			set_cfg(m, cnt);
			if (cnt > 1 && $urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, cnt - 1);
				send_random(k);
				drain();
				if ($urandom_range(0, 1) == 0)
					apb_write({REG_CODE_MODE, 2'b00}, 32'($urandom_range(0, 3)));
				else
					apb_write({REG_BYTE_COUNT, 2'b00}, 32'(k + $urandom_range(1, 12)));
			end
			finish_frame();
		end

		drain();
		repeat (4 * SETTLE) @(posedge clk);
		if (error_count == 0 && codeword_q.size() == 0)
			$display("dvbs2_bch_encoder test passed");
		else
			$display("dvbs2_bch_encoder test failed");
		$finish;
	end

endmodule
